>>> hw/rtl/ksc_pkg.sv
// Shared types and constants of the keyed byte scramble cipher.
package ksc_pkg;

  // Register select codes, taken from paddr[4:3].
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  // Status codes reported on the final result transfer.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY_KEY  = 3'd1;
  localparam logic [2:0] ST_EMPTY_DATA = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  // Operation of one pass over the message buffer.
  typedef enum logic [2:0] {
    OP_PREP = 3'd0,
    OP_ROTL = 3'd1,
    OP_ROTR = 3'd2,
    OP_XOR1 = 3'd3,
    OP_XOR3 = 3'd4,
    OP_BITL = 3'd5,
    OP_BITR = 3'd6
  } op_e;

  // Key configuration as held by the register block.
  typedef struct packed {
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_len;
  } key_cfg_t;

endpackage

>>> hw/rtl/ksc_mem.sv
// Byte memory with one write port and one registered read port.
module ksc_mem #(
  parameter int Depth = 64,
  parameter int Aw    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/ksc_cfg.sv
// APB register block holding the key bytes and the key length.
module ksc_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output ksc_pkg::key_cfg_t cfg_o
);

  ksc_pkg::key_cfg_t cfg_q, cfg_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:3])
        ksc_pkg::REG_KEY_LOW:  cfg_d.key_low  = pwdata;
        ksc_pkg::REG_KEY_HIGH: cfg_d.key_high = pwdata;
        ksc_pkg::REG_KEY_LEN:  cfg_d.key_len  = pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[4:3])
      ksc_pkg::REG_KEY_LOW:  prdata = cfg_q.key_low;
      ksc_pkg::REG_KEY_HIGH: prdata = cfg_q.key_high;
      ksc_pkg::REG_KEY_LEN:  prdata = {59'd0, cfg_q.key_len};
      default:               prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/keyed_byte_scramble_cipher.sv
// Keyed byte scramble cipher. Message bytes are taken one per transfer while the block is idle
// and written to a byte buffer; the transfer marked last starts the work. The key is first
// compacted, then one preparation pass and five passes per key byte each stream the whole
// message from one buffer memory to the other, one byte per cycle; before each key byte a small
// setup loop reduces the key byte to its line length and shift amounts. Result bytes then
// leave one at a time, each read from the buffer once the output register can take it, and
// no new message is taken until all of them have been issued.
module keyed_byte_scramble_cipher #(
  parameter int BUFFER_BYTES  = 64,
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Message input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [0] func, [1] carries_byte
  input  logic        s_axis_tlast,
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
  output logic        m_axis_tuser,   // [0] byte_present
  output logic        m_axis_tlast
);

  localparam int Aw  = $clog2(BUFFER_BYTES);
  localparam int Cw  = $clog2(BUFFER_BYTES + 1);
  localparam int Lw  = Cw + 1;
  localparam int Kw  = $clog2(MAX_KEY_BYTES + 1);
  localparam int Kiw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_KEY       = 7'b0000010,
    S_SETUP     = 7'b0000100,
    S_PASS      = 7'b0001000,
    S_OUT_ISSUE = 7'b0010000,
    S_OUT_DATA  = 7'b0100000,
    S_EMPTY     = 7'b1000000
  } state_e;

  // Rotate a byte left.
  function automatic logic [7:0] rotl8(input logic [7:0] b, input logic [2:0] amt);
    logic [15:0] w;
    w = {b, b} << amt;
    return w[15:8];
  endfunction

  // Starting key index of an XOR pass: offset modulo key count.
  function automatic logic [Kiw-1:0] key_off(input logic [Kw-1:0] kn, input logic off3);
    logic [Kiw-1:0] r;
    if (!off3) begin
      r = (kn == Kw'(1)) ? Kiw'(0) : Kiw'(1);
    end else if (kn == Kw'(1) || kn == Kw'(3)) begin
      r = Kiw'(0);
    end else if (kn == Kw'(2)) begin
      r = Kiw'(1);
    end else begin
      r = Kiw'(3);
    end
    return r;
  endfunction

  // Operation of each pass within a key round.
  function automatic ksc_pkg::op_e pass_op(input logic dec, input logic [2:0] pass);
    ksc_pkg::op_e o;
    case (pass)
      3'd0:    o = dec ? ksc_pkg::OP_BITR : ksc_pkg::OP_ROTL;
      3'd1:    o = dec ? ksc_pkg::OP_XOR3 : ksc_pkg::OP_XOR1;
      3'd2:    o = dec ? ksc_pkg::OP_ROTL : ksc_pkg::OP_ROTR;
      3'd3:    o = dec ? ksc_pkg::OP_XOR1 : ksc_pkg::OP_XOR3;
      default: o = dec ? ksc_pkg::OP_ROTR : ksc_pkg::OP_BITL;
    endcase
    return o;
  endfunction

  ksc_pkg::key_cfg_t cfg;

  ksc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e         state_q, state_d;
  logic           open_q, open_d, mode_q, mode_d, ovf_q, ovf_d;
  logic [Cw-1:0]  cnt_q, cnt_d, n_q, n_d, i_q, i_d, p_q, p_d, start_q, start_d;
  logic [7:0]     kb_q [MAX_KEY_BYTES];
  logic           kb_we;
  logic [7:0]     kb_wdata;
  logic [Kw-1:0]  kn_q, kn_d, kc_q, kc_d;
  logic [Kiw-1:0] t_q, t_d, ki_q, ki_d, ki_cur, krd_idx;
  logic [2:0]     pass_q, pass_d;
  logic           prep_q, prep_d, init_q, init_d, src_b_q, src_b_d;
  logic [7:0]     m10_q, m10_d, m7_q, m7_d, sl_q, sl_d, sr_q, sr_d;
  logic [3:0]     j_q, j_d;
  logic           p1_q, p1_d, pk_q, pk_d, mis_q, mis_d;
  logic [Aw-1:0]  widx_q, widx_d;
  logic [7:0]     kx_q, kx_d;
  logic [2:0]     estat_q, estat_d;
  logic           ov_q, ov_d, opres_q, opres_d, olast_q, olast_d;
  logic [7:0]     obyte_q, obyte_d;
  logic [2:0]     ostat_q, ostat_d;

  logic [127:0]   key_all;
  logic [4:0]     len_eff;
  logic [7:0]     kbyte, ksrc, rdata, rdata_a, rdata_b, wdata;
  logic [Aw-1:0]  raddr, waddr;
  logic           we_a, we_b, in_acc, ofree, pwr;
  ksc_pkg::op_e   op;
  logic [3:0]     len4, s4;
  logic [4:0]     jl, srcl, srcr, line_src;
  logic           full;
  logic [Lw-1:0]  sum_n;
  logic [7:0]     len8;
  logic [3:0]     rbits;
  logic [2:0]     status;

  assign key_all  = {cfg.key_high, cfg.key_low};
  assign len_eff  = (cfg.key_len > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : cfg.key_len;
  assign ksrc     = key_all[8*4'(kc_q) +: 8];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign ofree    = !ov_q || m_axis_tready;
  assign op       = prep_q ? ksc_pkg::OP_PREP : pass_op(mode_q, pass_q);
  assign len4     = m10_q[3:0] + 4'd5;
  assign len8     = m10_q + 8'd5;
  assign rbits    = {1'b0, m7_q[2:0]} + 4'd1;
  assign status   = ovf_q ? ksc_pkg::ST_OVERFLOW : (mis_q ? ksc_pkg::ST_MISMATCH : ksc_pkg::ST_OK);
  assign rdata    = src_b_q ? rdata_b : rdata_a;
  assign pwr      = p1_q && (state_q == S_PASS);
  assign sum_n    = Lw'(kn_q) + Lw'(cnt_q);

  // Line geometry of the byte being issued.
  assign ki_cur   = (i_q == '0) ? key_off(kn_q, op == ksc_pkg::OP_XOR3) : ki_q;
  assign full     = (Lw'(p_q) + Lw'(len4)) <= Lw'(n_q);
  assign s4       = ((op == ksc_pkg::OP_ROTL) ^ mode_q) ? sl_q[3:0] : sr_q[3:0];
  assign jl       = {1'b0, j_q} + {1'b0, s4};
  assign srcl     = (jl >= {1'b0, len4}) ? jl - {1'b0, len4} : jl;
  assign srcr     = (j_q >= s4) ? {1'b0, j_q - s4} : {1'b0, j_q} + {1'b0, len4} - {1'b0, s4};
  assign line_src = (op == ksc_pkg::OP_ROTL) ? srcl : srcr;

  // Key byte select: one lookup per state.
  always_comb begin
    case (state_q)
      S_SETUP: krd_idx = t_q;
      S_PASS:  krd_idx = prep_q ? Kiw'(i_q) : ki_cur;
      default: krd_idx = Kiw'(i_q);
    endcase
  end
  assign kbyte = kb_q[krd_idx];

  // Buffer read address.
  always_comb begin
    raddr = Aw'(i_q);
    if (state_q == S_PASS) begin
      if (op == ksc_pkg::OP_PREP) begin
        raddr = (!mode_q && i_q >= Cw'(kn_q)) ? Aw'(i_q - Cw'(kn_q)) : Aw'(i_q);
      end else if ((op == ksc_pkg::OP_ROTL || op == ksc_pkg::OP_ROTR) && full) begin
        raddr = Aw'(p_q + Cw'(line_src));
      end
    end
  end

  // Buffer write data and address.
  always_comb begin
    case (op)
      ksc_pkg::OP_PREP:                   wdata = pk_q ? kx_q : rdata;
      ksc_pkg::OP_XOR1, ksc_pkg::OP_XOR3: wdata = rdata ^ kx_q;
      ksc_pkg::OP_BITL:                   wdata = rotl8(rdata, rbits[2:0]);
      ksc_pkg::OP_BITR:                   wdata = rotl8(rdata, 3'(4'd8 - rbits));
      default:                            wdata = rdata;
    endcase
  end

  always_comb begin
    waddr = widx_q;
    we_a  = pwr && src_b_q;
    we_b  = pwr && !src_b_q;
    if (state_q == S_IDLE) begin
      waddr = Aw'(open_q ? cnt_q : '0);
      we_a  = in_acc && s_axis_tuser[1] && ((open_q ? cnt_q : '0) < Cw'(BUFFER_BYTES));
    end
  end

  ksc_mem #(.Depth(BUFFER_BYTES), .Aw(Aw)) u_mem_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (state_q == S_IDLE ? s_axis_tdata : wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  ksc_mem #(.Depth(BUFFER_BYTES), .Aw(Aw)) u_mem_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_b)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'd0, ostat_q, obyte_q};
  assign m_axis_tuser  = opres_q;
  assign m_axis_tlast  = olast_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    open_d  = open_q;  mode_d  = mode_q;  ovf_d   = ovf_q;   cnt_d  = cnt_q;
    n_d     = n_q;     i_d     = i_q;     p_d     = p_q;     j_d    = j_q;
    start_d = start_q; kn_d    = kn_q;    kc_d    = kc_q;    t_d    = t_q;
    ki_d    = ki_q;    pass_d  = pass_q;  prep_d  = prep_q;  init_d = init_q;
    src_b_d = src_b_q; m10_d   = m10_q;   m7_d    = m7_q;    sl_d   = sl_q;
    sr_d    = sr_q;    p1_d    = 1'b0;    pk_d    = pk_q;    mis_d  = mis_q;
    widx_d  = widx_q;  kx_d    = kx_q;    estat_d = estat_q;
    kb_we   = 1'b0;    kb_wdata = ksrc;
    ov_d    = ov_q && !m_axis_tready;
    opres_d = opres_q; olast_d = olast_q; obyte_d = obyte_q; ostat_d = ostat_q;

    unique case (state_q)
      // Collect message bytes.
      S_IDLE: begin
        if (in_acc) begin
          if (!open_q) begin
            mode_d = s_axis_tuser[0];
            cnt_d  = '0;
            ovf_d  = 1'b0;
          end
          if (s_axis_tuser[1]) begin
            if ((open_q ? cnt_q : '0) < Cw'(BUFFER_BYTES)) begin
              cnt_d = (open_q ? cnt_q : '0) + Cw'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          open_d = !s_axis_tlast;
          if (s_axis_tlast) begin
            kc_d    = '0;
            kn_d    = '0;
            state_d = S_KEY;
          end
        end
      end
      // Compact the ASCII key bytes, then choose the path.
      S_KEY: begin
        if (kc_q == Kw'(MAX_KEY_BYTES)) begin
          src_b_d = 1'b0;
          if (kn_q == '0) begin
            estat_d = ksc_pkg::ST_EMPTY_KEY;
            state_d = S_EMPTY;
          end else if (cnt_q == '0) begin
            estat_d = ksc_pkg::ST_EMPTY_DATA;
            state_d = S_EMPTY;
          end else begin
            if (!mode_q) begin
              if (sum_n > Lw'(BUFFER_BYTES)) begin
                n_d   = Cw'(BUFFER_BYTES);
                ovf_d = 1'b1;
              end else begin
                n_d = Cw'(sum_n);
              end
            end else begin
              n_d = cnt_q;
            end
            prep_d  = 1'b1;
            i_d     = '0;
            j_d     = '0;
            p_d     = '0;
            state_d = S_PASS;
          end
        end else begin
          if (5'(kc_q) < len_eff && !ksrc[7]) begin
            kb_we = 1'b1;
            kn_d  = kn_q + Kw'(1);
          end
          kc_d = kc_q + Kw'(1);
        end
      end
      // Reduce the key byte to line length, shifts and bit rotation.
      S_SETUP: begin
        if (init_q) begin
          init_d = 1'b0;
          m10_d  = kbyte;
          m7_d   = kbyte + 8'd4;
          sl_d   = kbyte;
          sr_d   = kbyte + 8'd2;
        end else if (m10_q < 8'd10 && m7_q < 8'd7 && sl_q < len8 && sr_q < len8) begin
          pass_d  = '0;
          i_d     = '0;
          j_d     = '0;
          p_d     = '0;
          state_d = S_PASS;
        end else begin
          if (m10_q >= 8'd10) m10_d = m10_q - 8'd10;
          if (m7_q >= 8'd7)   m7_d  = m7_q - 8'd7;
          if (m10_q < 8'd10) begin
            if (sl_q >= len8) sl_d = sl_q - len8;
            if (sr_q >= len8) sr_d = sr_q - len8;
          end
        end
      end
      // Stream the buffer from one memory to the other.
      S_PASS: begin
        if (i_q < n_q) begin
          p1_d   = 1'b1;
          widx_d = Aw'(i_q);
          kx_d   = kbyte;
          pk_d   = !mode_q && (i_q < Cw'(kn_q));
          ki_d   = ((Kw'(ki_cur) + Kw'(1)) == kn_q) ? '0 : ki_cur + Kiw'(1);
          i_d    = i_q + Cw'(1);
          if (j_q + 4'd1 == len4) begin
            j_d = '0;
            p_d = p_q + Cw'(len4);
          end else begin
            j_d = j_q + 4'd1;
          end
        end else if (!p1_q) begin
          src_b_d = !src_b_q;
          i_d     = '0;
          j_d     = '0;
          p_d     = '0;
          if (prep_q) begin
            prep_d  = 1'b0;
            t_d     = mode_q ? Kiw'(kn_q - Kw'(1)) : '0;
            init_d  = 1'b1;
            state_d = S_SETUP;
          end else if (pass_q != 3'd4) begin
            pass_d = pass_q + 3'd1;
          end else if (mode_q ? (t_q == '0) : ((Kw'(t_q) + Kw'(1)) == kn_q)) begin
            mis_d   = mode_q && (n_q < Cw'(kn_q));
            start_d = !mode_q ? '0 : ((n_q < Cw'(kn_q)) ? n_q : Cw'(kn_q));
            state_d = S_OUT_ISSUE;
          end else begin
            t_d     = mode_q ? t_q - Kiw'(1) : t_q + Kiw'(1);
            init_d  = 1'b1;
            state_d = S_SETUP;
          end
        end
      end
      // Read the next byte once the output register can take it.
      S_OUT_ISSUE: begin
        if (i_q == n_q) begin
          if (start_q >= n_q) begin
            estat_d = status;
            state_d = S_EMPTY;
          end else begin
            state_d = S_IDLE;
          end
        end else if (ofree) begin
          state_d = S_OUT_DATA;
        end
      end
      // Check the key prefix or present a result byte.
      S_OUT_DATA: begin
        if (i_q < start_q) begin
          if (rdata != kbyte) mis_d = 1'b1;
        end else begin
          ov_d    = 1'b1;
          obyte_d = rdata;
          opres_d = 1'b1;
          olast_d = (i_q + Cw'(1) == n_q);
          ostat_d = (i_q + Cw'(1) == n_q) ? status : ksc_pkg::ST_OK;
        end
        i_d     = i_q + Cw'(1);
        state_d = S_OUT_ISSUE;
      end
      // Single result transfer without a byte.
      S_EMPTY: begin
        if (ofree) begin
          ov_d    = 1'b1;
          obyte_d = 8'd0;
          opres_d = 1'b0;
          olast_d = 1'b1;
          ostat_d = estat_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Compacted key bytes.
  always_ff @(posedge clk_i) begin
    if (kb_we) begin
      kb_q[Kiw'(kn_q)] <= kb_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;     p_q    <= p_d;    j_q    <= j_d;    start_q <= start_d;
    t_q     <= t_d;     ki_q   <= ki_d;   pass_q <= pass_d; m10_q   <= m10_d;
    m7_q    <= m7_d;    sl_q   <= sl_d;   sr_q   <= sr_d;   pk_q    <= pk_d;
    widx_q  <= widx_d;  kx_q   <= kx_d;   estat_q <= estat_d;
    obyte_q <= obyte_d; opres_q <= opres_d; olast_q <= olast_d; ostat_q <= ostat_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      open_q  <= 1'b0;
      mode_q  <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      i_q     <= '0;
      kn_q    <= '0;
      kc_q    <= '0;
      prep_q  <= 1'b0;
      init_q  <= 1'b0;
      src_b_q <= 1'b0;
      p1_q    <= 1'b0;
      mis_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      mode_q  <= mode_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      kn_q    <= kn_d;
      kc_q    <= kc_d;
      prep_q  <= prep_d;
      init_q  <= init_d;
      src_b_q <= src_b_d;
      p1_q    <= p1_d;
      mis_q   <= mis_d;
      ov_q    <= ov_d;
    end
  end

endmodule

>>> test/tb_top.sv
// Testbench for the keyed byte scramble cipher: random and directed messages checked per transfer.

// Scoreboard: predicts result transfers of each message and checks them in order.
class cipher_scoreboard;
  typedef struct packed {
    logic [7:0] out_byte;
    logic       present;
    logic       end_flag;
    logic [2:0] status;
  } result_t;

  logic [63:0] key_lo, key_hi;
  logic [4:0]  key_len;
  logic [7:0]  msg_buf[64];
  int          msg_cnt;
  bit          dec_mode, ovf, open_msg;
  result_t     pending[$];
  int          errors;

  function new();
    key_lo = '0; key_hi = '0; key_len = '0;
    msg_cnt = 0; dec_mode = 0; ovf = 0; open_msg = 0; errors = 0;
  endfunction

  // Rotate every full line of length len left or right.
  static function void rotate_lines(ref logic [7:0] w[64], input int n, input int len,
                                    input int amount, input bit right);
    logic [7:0] tmp[16];
    int s;
    s = amount % len;
    if (s == 0) return;
    for (int l = 0; l < n / len; l++) begin
      for (int j = 0; j < len; j++)
        tmp[j] = right ? w[l*len + (j + len - s) % len] : w[l*len + (j + s) % len];
      for (int j = 0; j < len; j++) w[l*len + j] = tmp[j];
    end
  endfunction

  function void note_input(bit func, logic [7:0] data, bit carries, bit last);
    logic [7:0] kb[16];
    logic [7:0] w[64];
    logic [7:0] b;
    int k, n, lim, start, r, len;
    bit mism;
    logic [2:0] st;
    if (!open_msg) begin
      dec_mode = func; msg_cnt = 0; ovf = 0; open_msg = 1;
    end
    if (carries) begin
      if (msg_cnt < 64) msg_buf[msg_cnt++] = data;
      else ovf = 1;
    end
    if (!last) return;
    open_msg = 0;
    // Compact the ASCII key bytes.
    k = 0;
    lim = (key_len > 16) ? 16 : key_len;
    for (int i = 0; i < lim; i++) begin
      b = (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
      if (b < 128) kb[k++] = b;
    end
    if (k == 0) begin
      pending.push_back({8'd0, 1'b0, 1'b1, ksc_pkg::ST_EMPTY_KEY});
      return;
    end
    if (msg_cnt == 0) begin
      pending.push_back({8'd0, 1'b0, 1'b1, ksc_pkg::ST_EMPTY_DATA});
      return;
    end
    n = 0; start = 0; mism = 0;
    if (!dec_mode) begin
      for (int i = 0; i < k; i++) w[n++] = kb[i];
      for (int i = 0; i < msg_cnt; i++)
        if (n < 64) w[n++] = msg_buf[i];
        else ovf = 1;
      for (int t = 0; t < k; t++) begin
        len = kb[t] % 10 + 5;
        r = (kb[t] + 4) % 7 + 1;
        rotate_lines(w, n, len, kb[t], 0);
        for (int i = 0; i < n; i++) w[i] ^= kb[(i + 1) % k];
        rotate_lines(w, n, len, kb[t] + 2, 1);
        for (int i = 0; i < n; i++) w[i] ^= kb[(i + 3) % k];
        for (int i = 0; i < n; i++) w[i] = (w[i] << r) | (w[i] >> (8 - r));
      end
    end else begin
      for (int i = 0; i < msg_cnt; i++) w[n++] = msg_buf[i];
      for (int t = k - 1; t >= 0; t--) begin
        len = kb[t] % 10 + 5;
        r = (kb[t] + 4) % 7 + 1;
        for (int i = 0; i < n; i++) w[i] = (w[i] >> r) | (w[i] << (8 - r));
        for (int i = 0; i < n; i++) w[i] ^= kb[(i + 3) % k];
        rotate_lines(w, n, len, kb[t] + 2, 0);
        for (int i = 0; i < n; i++) w[i] ^= kb[(i + 1) % k];
        rotate_lines(w, n, len, kb[t], 1);
      end
      if (n < k) mism = 1;
      else for (int i = 0; i < k; i++) if (w[i] != kb[i]) mism = 1;
      start = (n < k) ? n : k;
    end
    st = ovf ? ksc_pkg::ST_OVERFLOW : (mism ? ksc_pkg::ST_MISMATCH : ksc_pkg::ST_OK);
    if (start >= n) begin
      pending.push_back({8'd0, 1'b0, 1'b1, st});
      return;
    end
    for (int i = start; i < n; i++)
      pending.push_back({w[i], 1'b1, i == n - 1, (i == n - 1) ? st : 3'd0});
  endfunction

  function void check_result(logic [7:0] ob, logic pr, logic eo, logic [2:0] st);
    result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result transfer: byte %0h", ob);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (ob !== e.out_byte) begin
      $error("out_byte: expected %0h, got %0h", e.out_byte, ob); errors++;
    end
    if (pr !== e.present) begin
      $error("byte_present: expected %0b, got %0b", e.present, pr); errors++;
    end
    if (eo !== e.end_flag) begin
      $error("end_of_result: expected %0b, got %0b", e.end_flag, eo); errors++;
    end
    if (st !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, st); errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 5_000_000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser = '0;   // [0] func, [1] carries_byte
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;        // [7:0] out_byte, [10:8] status
  logic        m_axis_tuser;        // [0] byte_present
  logic        m_axis_tlast;

  cipher_scoreboard sb;
  int  cycles = 0;
  bit  sink_quiet = 0;
  int  items_sent = 0;

  keyed_byte_scramble_cipher uut (.*);

  always #5 clk_i = ~clk_i;

  // Cycle counter with a hard stop.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result sampling at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[10:8]);
    end
  end

  // Receiver with random stalls per transfer; some stretches never stall.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = sink_quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      ksc_pkg::REG_KEY_LOW:  sb.key_lo = val;
      ksc_pkg::REG_KEY_HIGH: sb.key_hi = val;
      default:               sb.key_len = val[4:0];
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (7000) @(posedge clk_i);
  endtask

  task automatic set_key(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    wait_drained();
    reg_write(ksc_pkg::REG_KEY_LOW, lo);
    reg_write(ksc_pkg::REG_KEY_HIGH, hi);
    reg_write(ksc_pkg::REG_KEY_LEN, {59'd0, len});
  endtask

  // One input transfer, with a random gap before it unless quiet.
  task automatic send_item(bit func, logic [7:0] data, bit carries, bit last, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= {carries, func};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(func, data, carries, last);
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  task automatic send_message(bit func, int len, bit quiet);
    if (len == 0) send_item(func, 8'($urandom), 1'b0, 1'b1, quiet);
    for (int i = 0; i < len; i++)
      send_item(func, 8'($urandom), 1'b1, i == len - 1, quiet);
  endtask

  function automatic logic [63:0] rand_key_word(bit ascii);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (ascii) for (int i = 0; i < 8; i++) w[8*i+7] = 1'b0;
    return w;
  endfunction

  // Encrypts with the predictor and feeds the cipher text back for decryption.
  task automatic encrypt_then_decrypt(int len, bit flip);
    cipher_scoreboard shadow;
    logic [7:0] pt[$];
    logic [7:0] ct[$];
    int pos;
    shadow = new();
    shadow.key_lo = sb.key_lo; shadow.key_hi = sb.key_hi; shadow.key_len = sb.key_len;
    for (int i = 0; i < len; i++) pt.push_back(8'($urandom));
    for (int i = 0; i < len; i++) shadow.note_input(1'b0, pt[i], 1'b1, i == len - 1);
    foreach (shadow.pending[i])
      if (shadow.pending[i].present) ct.push_back(shadow.pending[i].out_byte);
    for (int i = 0; i < len; i++) send_item(1'b0, pt[i], 1'b1, i == len - 1, 1'b0);
    if (flip && ct.size() > 0) begin
      pos = $urandom_range(0, ct.size() - 1);
      ct[pos][$urandom_range(0, 7)] ^= 1'b1;
    end
    if (ct.size() == 0) send_item(1'b1, 8'd0, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < ct.size(); i++)
      send_item(1'b1, ct[i], 1'b1, i == ct.size() - 1, 1'b0);
  endtask

  initial begin
    int len;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Empty key status with reset registers, then the empty-data marker.
    send_message(0, 3, 1);
    set_key(64'h4B_45_59_21_61_62_63_64, 64'h0, 5'd4);
    send_message(0, 0, 0);
    send_message(1, 0, 0);
    // Short message, one byte, and decryption shorter than the key.
    send_item(0, 8'h00, 1, 1, 0);
    send_item(0, 8'hFF, 0, 0, 0);
    send_item(1, 8'hAA, 1, 0, 0);
    send_item(0, 8'h55, 1, 1, 0);
    send_message(1, 2, 0);
    encrypt_then_decrypt(5, 0);
    // Full 16-byte key with overflow on encrypt and decrypt.
    set_key(64'h7F_00_41_42_7E_30_31_32, 64'h20_21_22_23_24_25_26_27, 5'd31);
    send_message(0, 50, 1);
    send_message(1, 66, 1);
    // All key bytes non-ASCII gives empty key, as does a zero key length.
    set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'h8080_8080_8080_8080, 5'd16);
    send_message(0, 2, 0);
    set_key(64'h0, 64'h0, 5'd0);
    send_message(1, 1, 0);

    // Random phases with several key settings.
    for (int phase = 0; items_sent < 280; phase++) begin
      set_key(rand_key_word($urandom_range(0, 3) != 0), rand_key_word($urandom_range(0, 3) != 0),
              5'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4)));
      sink_quiet = (phase % 4 == 3);
      for (int m = 0; m < 3 && items_sent < 280; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0, 1: encrypt_then_decrypt(len, $urandom_range(0, 3) == 0);
          2: send_message(1'($urandom_range(0, 1)), len, 1'b0);
          default: begin
            for (int i = 0; i < len; i++)
              send_item(1'($urandom), 8'($urandom), 1'($urandom), i == len - 1, 1'b0);
          end
        endcase
      end
      // The sender holds off until every expected result has arrived.
      while (sb.pending.size() != 0) @(posedge clk_i);
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (7000) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
